>>> rtl/core/ptr_pkg.sv
`default_nettype none

package ptr_pkg;

	localparam int FEAT_W   = 16;
	localparam int NUM_FEAT = 3;
	localparam int SAMPLE_W = NUM_FEAT * FEAT_W + 1;
	localparam int WEIGHT_W = 32;
	localparam int PROD_W   = WEIGHT_W + FEAT_W;
	localparam int DOT_W    = PROD_W + 2;
	localparam int UPD_W    = 16;
	localparam int EXAM_W   = 24;

	localparam logic [EXAM_W-1:0] EXAM_MAX        = {EXAM_W{1'b1}};
	localparam logic [UPD_W-1:0]  MAX_UPDATES_RST = 16'd1024;

	// commands from the controller to the datapath
	typedef struct packed {
		logic cfg_we;
		logic load;
		logic rd;
		logic mul;
		logic sum;
		logic decide;
		logic out_load;
	} ptr_cmd_t;

	// status back to the controller, valid in the decide state
	typedef struct packed {
		logic miss;
		logic limit_hit;
		logic pass_done;
	} ptr_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/ptr_ram.sv
`default_nettype none

module ptr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                       wr_data,
	input  wire logic                                   rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/ptr_dp.sv
`default_nettype none

module ptr_dp import ptr_pkg::*; #(
	parameter int MAX_SAMPLES = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ptr_cmd_t                   cmd,
	output ptr_sts_t                        sts,
	input  wire logic [UPD_W-1:0]           cfg_data,
	input  wire logic signed [FEAT_W-1:0]   feature_zero,
	input  wire logic signed [FEAT_W-1:0]   feature_one,
	input  wire logic signed [FEAT_W-1:0]   feature_two,
	input  wire logic                       label_positive,
	input  wire logic                       last_sample,
	output logic signed [WEIGHT_W-1:0]      weight_zero,
	output logic signed [WEIGHT_W-1:0]      weight_one,
	output logic signed [WEIGHT_W-1:0]      weight_two,
	output logic        [EXAM_W-1:0]        examinations,
	output logic                            converged
);

	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SAMPLES);

	logic [CW-1:0]              cnt_q;
	logic [CW-1:0]              train_cnt_q;
	logic [CW-1:0]              clean_q;
	logic [AW-1:0]              scan_q;
	logic [UPD_W-1:0]           upd_q;
	logic [UPD_W-1:0]           max_upd_q;
	logic [EXAM_W-1:0]          exam_q;
	logic                       conv_q;
	logic signed [WEIGHT_W-1:0] w_q [NUM_FEAT];
	logic signed [PROD_W-1:0]   prod_s1 [NUM_FEAT];
	logic signed [DOT_W-1:0]    dot_s2;

	logic [CW-1:0]              cnt_after;
	logic                       store_room;
	logic [SAMPLE_W-1:0]        rd_data;
	logic signed [FEAT_W-1:0]   feat [NUM_FEAT];
	logic                       lbl;
	logic [UPD_W-1:0]           upd_next;
	logic [CW-1:0]              clean_next;
	logic                       dot_neg;
	logic                       dot_zero;
	logic signed [WEIGHT_W:0]   w_sum [NUM_FEAT];
	logic signed [WEIGHT_W-1:0] w_new [NUM_FEAT];

	assign store_room = (cnt_q < CNT_MAX);
	assign cnt_after  = store_room ? cnt_q + 1'b1 : cnt_q;

	ptr_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.load && store_room),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data ({label_positive, feature_two, feature_one, feature_zero}),
		.rd_en   (cmd.rd),
		.rd_addr (scan_q),
		.rd_data (rd_data)
	);

	// read data holds between reads, so it serves the whole examination
	always_comb begin
		for (int k = 0; k < NUM_FEAT; k++) begin
			feat[k] = rd_data[k*FEAT_W +: FEAT_W];
		end
	end
	assign lbl = rd_data[SAMPLE_W-1];

	assign dot_neg  = dot_s2[DOT_W-1];
	assign dot_zero = (dot_s2 == '0);

	assign upd_next   = upd_q + 1'b1;
	assign clean_next = clean_q + 1'b1;

	assign sts.miss      = lbl ? (dot_neg || dot_zero) : !dot_neg;
	assign sts.limit_hit = (upd_next >= max_upd_q);
	assign sts.pass_done = (clean_next >= train_cnt_q);

	// weight plus or minus feature, clamped to 32 bits signed
	always_comb begin
		for (int k = 0; k < NUM_FEAT; k++) begin
			w_sum[k] = lbl ? ((WEIGHT_W+1)'(w_q[k]) + (WEIGHT_W+1)'(feat[k]))
			               : ((WEIGHT_W+1)'(w_q[k]) - (WEIGHT_W+1)'(feat[k]));
			if (w_sum[k][WEIGHT_W] != w_sum[k][WEIGHT_W-1]) begin
				w_new[k] = w_sum[k][WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
				                              : {1'b0, {(WEIGHT_W-1){1'b1}}};
			end else begin
				w_new[k] = w_sum[k][WEIGHT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			train_cnt_q <= '0;
			clean_q     <= '0;
			scan_q      <= '0;
			upd_q       <= '0;
			exam_q      <= '0;
			conv_q      <= 1'b0;
			max_upd_q   <= MAX_UPDATES_RST;
			for (int k = 0; k < NUM_FEAT; k++) begin
				w_q[k] <= '0;
			end
		end else begin
			if (cmd.cfg_we) begin
				max_upd_q <= cfg_data;
			end
			if (cmd.load) begin
				if (last_sample) begin
					cnt_q       <= '0;
					train_cnt_q <= cnt_after;
					clean_q     <= '0;
					scan_q      <= '0;
					upd_q       <= '0;
					exam_q      <= '0;
					conv_q      <= 1'b0;
					for (int k = 0; k < NUM_FEAT; k++) begin
						w_q[k] <= '0;
					end
				end else begin
					cnt_q <= cnt_after;
				end
			end
			if (cmd.decide) begin
				if (exam_q != EXAM_MAX) begin
					exam_q <= exam_q + 1'b1;
				end
				if (sts.miss) begin
					for (int k = 0; k < NUM_FEAT; k++) begin
						w_q[k] <= w_new[k];
					end
					upd_q   <= upd_next;
					scan_q  <= '0;
					clean_q <= '0;
					conv_q  <= 1'b0;
				end else begin
					clean_q <= clean_next;
					scan_q  <= scan_q + 1'b1;
					conv_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			for (int k = 0; k < NUM_FEAT; k++) begin
				prod_s1[k] <= PROD_W'(w_q[k]) * PROD_W'(feat[k]);
			end
		end
		if (cmd.sum) begin
			dot_s2 <= DOT_W'(prod_s1[0]) + DOT_W'(prod_s1[1]) + DOT_W'(prod_s1[2]);
		end
		if (cmd.out_load) begin
			weight_zero  <= w_q[0];
			weight_one   <= w_q[1];
			weight_two   <= w_q[2];
			examinations <= exam_q;
			converged    <= conv_q;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/ptr_ctrl.sv
`default_nettype none

module ptr_ctrl import ptr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire logic     last_sample,
	output logic          out_valid,
	input  wire logic     out_stall,
	input  wire logic     cfg_valid,
	output logic          cfg_ready,
	output ptr_cmd_t      cmd,
	input  wire ptr_sts_t sts
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_READ   = 3'd1;
	localparam logic [2:0] S_MUL    = 3'd2;
	localparam logic [2:0] S_SUM    = 3'd3;
	localparam logic [2:0] S_DECIDE = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       out_valid_q;
	logic       accept;
	logic       finish;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	assign cmd.cfg_we   = cfg_valid;
	assign cmd.load     = accept;
	assign cmd.rd       = (state_q == S_READ);
	assign cmd.mul      = (state_q == S_MUL);
	assign cmd.sum      = (state_q == S_SUM);
	assign cmd.decide   = (state_q == S_DECIDE);
	assign cmd.out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// stop on a clean full pass or when the update limit is reached
	assign finish = sts.miss ? sts.limit_hit : sts.pass_done;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && last_sample) begin
					state_nx = S_READ;
				end
			end
			S_READ:   state_nx = S_MUL;
			S_MUL:    state_nx = S_SUM;
			S_SUM:    state_nx = S_DECIDE;
			S_DECIDE: state_nx = finish ? S_DONE : S_READ;
			S_DONE: begin
				if (cmd.out_load) begin
					state_nx = S_IDLE;
				end
			end
			default:  state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/perceptron_trainer.sv
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   feature_zero/one/two, label_positive, last_sample
// out      output     out_valid / out_stall weight_zero/one/two, examinations, converged
// cfg      input      cfg_valid / cfg_ready cfg_data (max_updates)
//
// a non-last sample leaves in_stall low, so the next sample may follow at once
// training repeats examinations of store read, three multiplies, sum and decide;
// at the end the result register is loaded once the output is free
// in_stall is high from the last sample until the result register is loaded
// the result holds while out_valid and out_stall are high; samples may load meanwhile
// reset clears the sample count, weights and counters; max_updates resets to 1024
`default_nettype none

module perceptron_trainer import ptr_pkg::*; #(
	parameter int MAX_SAMPLES = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [FEAT_W-1:0] feature_zero,
	input  wire logic signed [FEAT_W-1:0] feature_one,
	input  wire logic signed [FEAT_W-1:0] feature_two,
	input  wire logic                     label_positive,
	input  wire logic                     last_sample,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [WEIGHT_W-1:0]    weight_zero,
	output logic signed [WEIGHT_W-1:0]    weight_one,
	output logic signed [WEIGHT_W-1:0]    weight_two,
	output logic        [EXAM_W-1:0]      examinations,
	output logic                          converged,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [UPD_W-1:0]         cfg_data
);

	ptr_cmd_t cmd;
	ptr_sts_t sts;

	ptr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.last_sample (last_sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cmd         (cmd),
		.sts         (sts)
	);

	ptr_dp #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_data       (cfg_data),
		.feature_zero   (feature_zero),
		.feature_one    (feature_one),
		.feature_two    (feature_two),
		.label_positive (label_positive),
		.last_sample    (last_sample),
		.weight_zero    (weight_zero),
		.weight_one     (weight_one),
		.weight_two     (weight_two),
		.examinations   (examinations),
		.converged      (converged)
	);

endmodule

`default_nettype wire
